[rtl/core/blbs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blbs_pkg
// shared types and constants of the bounded log bucket sketch insert unit
// ----------------------------------------------------------------------------
package blbs_pkg;

  localparam int MAX_BINS_DEF = 64;
  localparam int KEY_BITS_DEF = 17;

  localparam logic [1:0] CLS_POS  = 2'd0;
  localparam logic [1:0] CLS_ZERO = 2'd1;
  localparam logic [1:0] CLS_NEG  = 2'd2;
  localparam logic [1:0] CLS_RSVD = 2'd3;

  localparam logic CFG_BIN_BOUND = 1'b0;
  localparam logic CFG_COLLAPSE  = 1'b1;

  localparam logic [5:0] BIN_BOUND_RST = 6'd63;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_SHRD,
    ST_SHWR,
    ST_INS,
    ST_MERGE,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic rd_search;
    logic step_i;
    logic rd_shift;
    logic wr_shift;
    logic wr_key;
    logic merge;
    logic emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic keyed_in;
    logic at_end;
    logic full;
    logic lt;
    logic eq;
    logic j_eq_i;
    logic over;
    logic can_merge;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

[rtl/core/blbs_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blbs request channels
// input request channel and result channel with valid/ready handshake
// ----------------------------------------------------------------------------
interface blbs_in_if #(parameter int KEY_BITS = 17);
  logic                       valid;
  logic                       ready;
  logic [1:0]                 sign_class;
  logic signed [KEY_BITS-1:0] bucket_key;
  logic                       last_in_batch;

  modport source (output valid, sign_class, bucket_key, last_in_batch, input ready);
  modport sink   (input valid, sign_class, bucket_key, last_in_batch, output ready);
endinterface

interface blbs_out_if;
  logic        valid;
  logic        ready;
  logic        new_bin;
  logic [6:0]  positive_bins;
  logic [6:0]  negative_bins;
  logic [5:0]  merges_this_step;
  logic [31:0] merge_total;
  logic [31:0] positive_population;
  logic [31:0] negative_population;
  logic        merge_blocked;
  logic        batch_end;

  modport source (output valid, new_bin, positive_bins, negative_bins, merges_this_step,
                  merge_total, positive_population, negative_population, merge_blocked,
                  batch_end, input ready);
  modport sink   (input valid, new_bin, positive_bins, negative_bins, merges_this_step,
                  merge_total, positive_population, negative_population, merge_blocked,
                  batch_end, output ready);
endinterface
`default_nettype wire

[rtl/core/blbs_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blbs_ctrl
// sequencer for search, insert shift, merge loop and result hand-off
// ----------------------------------------------------------------------------
module blbs_ctrl
  import blbs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = sts.keyed_in ? ST_SRCH : ST_MERGE;
        end
      end
      ST_SRCH: begin
        if (sts.at_end) begin
          state_next = sts.full ? ST_MERGE : ST_SHRD;
        end else begin
          cmd.rd_search = 1'b1;
          state_next    = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.lt) begin
          cmd.step_i = 1'b1;
          state_next = ST_SRCH;
        end else if (sts.eq || sts.full) begin
          state_next = ST_MERGE;
        end else begin
          state_next = ST_SHRD;
        end
      end
      ST_SHRD: begin
        if (sts.j_eq_i) begin
          state_next = ST_INS;
        end else begin
          cmd.rd_shift = 1'b1;
          state_next   = ST_SHWR;
        end
      end
      ST_SHWR: begin
        cmd.wr_shift = 1'b1;
        state_next   = ST_SHRD;
      end
      ST_INS: begin
        cmd.wr_key = 1'b1;
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        if (!sts.over || !sts.can_merge) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/blbs_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// blbs_datapath
// circular sorted key stores, counters, config registers and result register
// ----------------------------------------------------------------------------
module blbs_datapath
  import blbs_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [5:0]                 cfg_data,
  input  wire logic [1:0]                 in_sign_class,
  input  wire logic signed [KEY_BITS-1:0] in_bucket_key,
  input  wire logic                       in_last,
  input  wire cmd_t                       cmd,
  output sts_t                            sts,
  blbs_out_if.source                      res
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int MW = $clog2(2 * MAX_BINS);
  localparam logic [CW:0] MAX_EXT = (CW + 1)'(MAX_BINS);
  localparam logic [MW-1:0] MAX_MW = MW'(MAX_BINS);

  // two stores share one array, negative store in the upper half
  logic [KEY_BITS-1:0] keys_mem [2*MAX_BINS];

  logic [5:0]  bin_bound;
  logic        collapse_low;
  logic [1:0]  cls_r;
  logic signed [KEY_BITS-1:0] key_r;
  logic        last_r;
  logic [CW-1:0] i_idx, j_idx;
  logic [AW-1:0] head_p, head_n;
  logic [CW-1:0] used_p, used_n;
  logic        zero_present;
  logic [31:0] pos_pop, neg_pop, merge_cnt;
  logic [5:0]  merges;
  logic        created, blocked;
  logic signed [KEY_BITS-1:0] rdata;

  // head plus offset, wrapped into the ring
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(h) + (CW + 1)'(off);
    if (s >= MAX_EXT) begin
      s = s - MAX_EXT;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (&v) ? v : v + 32'd1;
  endfunction

  logic          sel;
  logic [AW-1:0] head_sel;
  logic [CW-1:0] used_sel;
  logic [AW-1:0] rd_ofs, wr_ofs;
  logic [MW-1:0] rd_addr, wr_addr;
  logic [CW:0]   total;

  assign sel      = cls_r[1];
  assign head_sel = sel ? head_n : head_p;
  assign used_sel = sel ? used_n : used_p;
  assign rd_ofs   = ring_add(head_sel, cmd.rd_shift ? j_idx - CW'(1) : i_idx);
  assign wr_ofs   = ring_add(head_sel, cmd.wr_shift ? j_idx : i_idx);
  assign rd_addr  = sel ? MW'(rd_ofs) + MAX_MW : MW'(rd_ofs);
  assign wr_addr  = sel ? MW'(wr_ofs) + MAX_MW : MW'(wr_ofs);
  assign total    = (CW + 1)'(used_p) + (CW + 1)'(used_n) + (CW + 1)'(zero_present);

  always_ff @(posedge clk) begin
    if (cmd.rd_search || cmd.rd_shift) begin
      rdata <= keys_mem[rd_addr];
    end
    if (cmd.wr_shift) begin
      keys_mem[wr_addr] <= rdata;
    end else if (cmd.wr_key) begin
      keys_mem[wr_addr] <= key_r;
    end
  end

  always_comb begin
    sts.keyed_in  = (in_sign_class == CLS_POS) || (in_sign_class == CLS_NEG);
    sts.at_end    = (i_idx == used_sel);
    sts.full      = (used_sel == CW'(MAX_BINS));
    sts.lt        = rdata < key_r;
    sts.eq        = rdata == key_r;
    sts.j_eq_i    = (j_idx == i_idx);
    sts.over      = total > (CW + 1)'(bin_bound);
    sts.can_merge = (used_p >= CW'(2)) || (used_n >= CW'(2));
    sts.out_free  = !res.valid || res.ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cls_r  <= in_sign_class;
      key_r  <= in_bucket_key;
      last_r <= in_last;
      i_idx  <= '0;
      j_idx  <= in_sign_class[1] ? used_n : used_p;
    end else begin
      if (cmd.step_i) begin
        i_idx <= i_idx + CW'(1);
      end
      if (cmd.wr_shift) begin
        j_idx <= j_idx - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_bound    <= BIN_BOUND_RST;
      collapse_low <= 1'b0;
      head_p       <= '0;
      head_n       <= '0;
      used_p       <= '0;
      used_n       <= '0;
      zero_present <= 1'b0;
      pos_pop      <= '0;
      neg_pop      <= '0;
      merge_cnt    <= '0;
      merges       <= '0;
      created      <= 1'b0;
      blocked      <= 1'b0;
      res.valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BIN_BOUND: bin_bound    <= cfg_data;
          CFG_COLLAPSE:  collapse_low <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        merges  <= '0;
        blocked <= 1'b0;
        created <= 1'b0;
        case (in_sign_class)
          CLS_POS: pos_pop <= sat_inc(pos_pop);
          CLS_ZERO: begin
            pos_pop      <= sat_inc(pos_pop);
            zero_present <= 1'b1;
            created      <= !zero_present;
          end
          CLS_NEG: neg_pop <= sat_inc(neg_pop);
          default: ;
        endcase
      end
      if (cmd.wr_key) begin
        created <= 1'b1;
        if (sel) begin
          used_n <= used_n + CW'(1);
        end else begin
          used_p <= used_p + CW'(1);
        end
      end
      if (cmd.merge && sts.over) begin
        if (!sts.can_merge) begin
          blocked <= 1'b1;
        end else begin
          merge_cnt <= sat_inc(merge_cnt);
          if (merges != 6'd63) begin
            merges <= merges + 6'd1;
          end
          if (!collapse_low) begin
            if (used_p >= CW'(2)) begin
              used_p <= used_p - CW'(1);
            end else begin
              used_n <= used_n - CW'(1);
              head_n <= ring_add(head_n, CW'(1));
            end
          end else begin
            if (used_n >= CW'(2)) begin
              used_n <= used_n - CW'(1);
            end else begin
              used_p <= used_p - CW'(1);
              head_p <= ring_add(head_p, CW'(1));
            end
          end
        end
      end
      if (cmd.emit) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  logic [CW:0] pos_bins_w;
  assign pos_bins_w = (CW + 1)'(used_p) + (CW + 1)'(zero_present);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.new_bin             <= created;
      res.positive_bins       <= 7'(pos_bins_w);
      res.negative_bins       <= 7'(used_n);
      res.merges_this_step    <= merges;
      res.merge_total         <= merge_cnt;
      res.positive_population <= pos_pop;
      res.negative_population <= neg_pop;
      res.merge_blocked       <= blocked;
      res.batch_end           <= last_r;
    end
  end

  a_used_p_bound: assert property (@(posedge clk) disable iff (rst)
    used_p <= CW'(MAX_BINS)) else $error("positive store overfilled");
  a_used_n_bound: assert property (@(posedge clk) disable iff (rst)
    used_n <= CW'(MAX_BINS)) else $error("negative store overfilled");
  a_merge_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.merge && sts.over && sts.can_merge |=> merge_cnt != 32'd0)
    else $error("merge not counted");
  a_insert_flag: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_key |=> created) else $error("insert without new bin flag");

endmodule
`default_nettype wire

[rtl/core/bounded_log_bucket_sketch_insert_unit.sv]
`default_nettype none
// sequence: search, then shift of the bins above and insert for a new keyed bin if the store
//   has room; the zero bucket skips the store; the merge loop then runs for every request
// throughput: one request at a time; scan and shift through the single key memory and the
//   merge loop set the rate, and a result not yet taken holds back the next request
// reset: synchronous, clears fill counts, heads, populations, merge total, collapse side and
//   result valid and sets bin_bound to 63; no key reset
// ----------------------------------------------------------------------------
// bounded_log_bucket_sketch_insert_unit
// bounded two-sided log bucket sketch: insert, then collapse end bins to the bound
// ----------------------------------------------------------------------------
module bounded_log_bucket_sketch_insert_unit
  import blbs_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // config write port: index 0 bin_bound, index 1 collapse_low_side
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [5:0] cfg_data,
  blbs_in_if.sink         req,
  blbs_out_if.source      res
);

  cmd_t cmd;
  sts_t sts;

  // controller walks the store, datapath holds keys and counters
  blbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  blbs_datapath #(
    .MAX_BINS (MAX_BINS),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_sign_class (req.sign_class),
    .in_bucket_key (req.bucket_key),
    .in_last       (req.last_in_batch),
    .cmd           (cmd),
    .sts           (sts),
    .res           (res)
  );

endmodule
`default_nettype wire
